[hdl/ipv4cs_pkg.sv]
package ipv4cs_pkg;

  // packet kind, sampled from the opcode on the first byte
  typedef enum logic [1:0] {
    KIND_IP   = 2'd0,
    KIND_TCP  = 2'd1,
    KIND_UDP  = 2'd2,
    KIND_ICMP = 2'd3
  } kind_t;

  // header offsets
  localparam int IP_CKSUM_HI_OFS = 10;
  localparam int IP_CKSUM_LO_OFS = 11;
  localparam int IP_PROTO_OFS    = 9;
  localparam int IP_SRC_FIRST    = 12;
  localparam int IP_DST_LAST     = 19;
  localparam int MIN_IHL         = 5;

  // checksum field offsets within the segment
  localparam int TCP_CKSUM_OFS  = 16;
  localparam int UDP_CKSUM_OFS  = 6;
  localparam int ICMP_CKSUM_OFS = 2;

  localparam logic [15:0] ALL_ONES = 16'hffff;

  typedef struct packed {
    logic [7:0] data_byte;
    logic [1:0] opcode;
    logic       last;
  } step_t;

  typedef struct packed {
    logic [15:0] checksum;
    logic        short_packet;
  } result_t;

  // ones-complement add with end-around carry
  function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[15:0] + {15'd0, s[16]};
  endfunction

endpackage

[hdl/ipv4_l4_checksum_engine_core.sv]
// IPv4 header / TCP / UDP / ICMP checksum engine. Bytes of one packet arrive
// in wire order from the first byte of the IPv4 header, one transaction per
// byte, with the mode given by in_opcode on the first byte. The block takes
// one byte every cycle while in_stall is low; the rate is set by the per-byte
// accumulate step, a 16-bit ones-complement add with end-around carry (plus
// the TCP/UDP pseudo-header length add on the final byte). A byte is
// captured in an input register and then folded into the running sum; a
// final byte's result is held in the output register. A result waits in
// the output register while out_stall is high; input is stalled only when a
// second final byte must wait behind a result that has not been taken.
// out_checksum is the complemented sum, high byte first on the wire;
// out_short_packet flags a packet shorter than its header or with ihl below 5,
// in which case the checksum reads zero.
module ipv4_l4_checksum_engine_core #(
  parameter int LENGTH_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic [1:0]  in_opcode,
  input  logic        in_last,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_checksum,
  output logic        out_short_packet
);

  // input register
  logic                s1_valid_r, s1_valid_nxt;
  ipv4cs_pkg::step_t   s1_r;
  logic                s1_adv;
  logic                in_take;

  // output register
  logic                out_valid_r, out_valid_nxt;
  ipv4cs_pkg::result_t out_r;
  ipv4cs_pkg::result_t acc_result;
  logic                load_out;

  // a byte that ends a packet can move on only if the output slot frees up
  assign s1_adv   = s1_valid_r && (!s1_r.last || !out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !s1_adv;
  assign in_take  = in_valid && !in_stall;
  assign load_out = s1_adv && s1_r.last;

  always_comb begin
    s1_valid_nxt = in_take ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_r);
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  ipv4cs_accum #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_accum (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (s1_adv),
    .step    (s1_r),
    .result  (acc_result)
  );

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_r.data_byte <= in_data_byte;
      s1_r.opcode    <= in_opcode;
      s1_r.last      <= in_last;
    end
    if (load_out) begin
      out_r <= acc_result;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_checksum     = out_r.checksum;
  assign out_short_packet = out_r.short_packet;

endmodule

[hdl/ipv4cs_accum.sv]
module ipv4cs_accum #(
  parameter int LENGTH_BITS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step_en,
  input  ipv4cs_pkg::step_t   step,
  output ipv4cs_pkg::result_t result
);

  logic [LENGTH_BITS-1:0] pos_r, pos_nxt;
  logic [3:0]             hw_r, hw_nxt;
  logic [15:0]            sum_r, sum_nxt;
  logic [7:0]             held_r, held_nxt;
  ipv4cs_pkg::kind_t      kind_r, kind_nxt;
  logic                   seg_r, seg_nxt;

  logic                   first;
  logic [3:0]             hw;
  ipv4cs_pkg::kind_t      kind;
  logic [5:0]             hdr_len;
  logic [LENGTH_BITS-1:0] off;
  logic [LENGTH_BITS-1:0] pos_p1;
  logic [LENGTH_BITS:0]   pos_p1_wide;
  logic [LENGTH_BITS-1:0] seg_len;
  logic                   counts;
  logic [7:0]             v;
  logic [15:0]            word;
  logic [15:0]            sum1;
  logic [15:0]            final_sum;
  logic                   seg_now;
  logic                   is_short;

  always_comb begin
    first       = (pos_r == '0) && !seg_r;
    hw          = first ? step.data_byte[3:0] : hw_r;
    kind        = first ? ipv4cs_pkg::kind_t'(step.opcode) : kind_r;
    hdr_len     = {hw, 2'b00};
    off         = pos_r - LENGTH_BITS'(hdr_len);
    pos_p1_wide = {1'b0, pos_r} + (LENGTH_BITS+1)'(1);
    pos_p1      = pos_p1_wide[LENGTH_BITS-1:0];
    seg_len     = pos_p1 - LENGTH_BITS'(hdr_len);

    // which bytes enter the sum
    counts = 1'b0;
    if (!seg_r) begin
      unique case (kind)
        ipv4cs_pkg::KIND_IP:
          counts = (pos_r != LENGTH_BITS'(ipv4cs_pkg::IP_CKSUM_HI_OFS)) &&
                   (pos_r != LENGTH_BITS'(ipv4cs_pkg::IP_CKSUM_LO_OFS));
        ipv4cs_pkg::KIND_TCP, ipv4cs_pkg::KIND_UDP:
          counts = (pos_r == LENGTH_BITS'(ipv4cs_pkg::IP_PROTO_OFS)) ||
                   ((pos_r >= LENGTH_BITS'(ipv4cs_pkg::IP_SRC_FIRST)) &&
                    (pos_r <= LENGTH_BITS'(ipv4cs_pkg::IP_DST_LAST)));
        ipv4cs_pkg::KIND_ICMP:
          counts = 1'b0;
        default:
          counts = 1'b0;
      endcase
    end else begin
      unique case (kind)
        ipv4cs_pkg::KIND_IP:
          counts = 1'b0;
        ipv4cs_pkg::KIND_TCP:
          counts = (off != LENGTH_BITS'(ipv4cs_pkg::TCP_CKSUM_OFS)) &&
                   (off != LENGTH_BITS'(ipv4cs_pkg::TCP_CKSUM_OFS + 1));
        ipv4cs_pkg::KIND_UDP:
          counts = (off != LENGTH_BITS'(ipv4cs_pkg::UDP_CKSUM_OFS)) &&
                   (off != LENGTH_BITS'(ipv4cs_pkg::UDP_CKSUM_OFS + 1));
        ipv4cs_pkg::KIND_ICMP:
          counts = (off != LENGTH_BITS'(ipv4cs_pkg::ICMP_CKSUM_OFS)) &&
                   (off != LENGTH_BITS'(ipv4cs_pkg::ICMP_CKSUM_OFS + 1));
        default:
          counts = 1'b0;
      endcase
    end

    v = counts ? step.data_byte : 8'h00;

    // even byte: padded word, only used when the packet ends here
    word = pos_r[0] ? {held_r, v} : {v, 8'h00};
    sum1 = ipv4cs_pkg::oc_add(sum_r, word);

    if ((kind == ipv4cs_pkg::KIND_TCP) || (kind == ipv4cs_pkg::KIND_UDP)) begin
      final_sum = ipv4cs_pkg::oc_add(sum1, 16'(seg_len));
    end else begin
      final_sum = sum1;
    end

    seg_now  = seg_r || (pos_p1_wide >= (LENGTH_BITS+1)'(hdr_len));
    is_short = (hw < 4'(ipv4cs_pkg::MIN_IHL)) || !seg_now;

    result.checksum     = is_short ? 16'h0000 : (final_sum ^ ipv4cs_pkg::ALL_ONES);
    result.short_packet = is_short;

    pos_nxt  = pos_r;
    hw_nxt   = hw_r;
    sum_nxt  = sum_r;
    held_nxt = held_r;
    kind_nxt = kind_r;
    seg_nxt  = seg_r;
    if (step_en) begin
      if (step.last) begin
        pos_nxt  = '0;
        hw_nxt   = '0;
        sum_nxt  = '0;
        held_nxt = '0;
        kind_nxt = ipv4cs_pkg::KIND_IP;
        seg_nxt  = 1'b0;
      end else begin
        pos_nxt  = pos_p1;
        hw_nxt   = hw;
        kind_nxt = kind;
        seg_nxt  = seg_now;
        if (pos_r[0]) begin
          sum_nxt = sum1;
        end else begin
          held_nxt = v;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      hw_r   <= '0;
      sum_r  <= '0;
      held_r <= '0;
      kind_r <= ipv4cs_pkg::KIND_IP;
      seg_r  <= 1'b0;
    end else begin
      pos_r  <= pos_nxt;
      hw_r   <= hw_nxt;
      sum_r  <= sum_nxt;
      held_r <= held_nxt;
      kind_r <= kind_nxt;
      seg_r  <= seg_nxt;
    end
  end

endmodule

[hdl/ipv4cs_checker.sv]
module ipv4cs_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        in_last,
  input logic        out_valid,
  input logic        out_stall,
  input logic [15:0] out_checksum,
  input logic        out_short_packet
);

  // a held result keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_checksum) &&
                               $stable(out_short_packet))
    else $error("result changed while stalled");

  // short packets report a zero checksum
  a_short_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_short_packet |-> out_checksum == 16'h0000)
    else $error("short packet with nonzero checksum");

  // input backpressure only behind a waiting result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a waiting result");

  // a fresh result must come from an accepted final byte
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && !in_stall && in_last, 2))
    else $error("result without a final byte");

endmodule

bind ipv4_l4_checksum_engine_core ipv4cs_checker u_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_stall         (in_stall),
  .in_last          (in_last),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_checksum     (out_checksum),
  .out_short_packet (out_short_packet)
);

[bench/ipv4_l4_checksum_engine_core_tb.sv]
module ipv4_l4_checksum_engine_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // one byte transaction as queued for the driver; typed rows carry a
  // hand-written result that replaces the predicted one
  typedef struct packed {
    logic [7:0]          data;
    ipv4cs_pkg::kind_t   op;
    logic                lst;
    logic                typed;
    logic [15:0]         ck;
    logic                sp;
  } row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_data_byte = 8'h00;
  logic [1:0]  in_opcode = ipv4cs_pkg::KIND_IP;
  logic        in_last = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [15:0] out_checksum;
  logic        out_short_packet;

  ipv4_l4_checksum_engine_core uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_data_byte     (in_data_byte),
    .in_opcode        (in_opcode),
    .in_last          (in_last),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_checksum     (out_checksum),
    .out_short_packet (out_short_packet)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // directed bytes: short packets first, then a textbook ipv4 header whose
  // stored checksum b861 must come back since the field reads as zero;
  // opcodes after the first byte of a packet vary and must be ignored
  row_t directed_tab [25] = '{
    '{8'h45, ipv4cs_pkg::KIND_IP,   1'b1, 1'b1, 16'h0000, 1'b1}, // last on the first byte
    '{8'h00, ipv4cs_pkg::KIND_TCP,  1'b1, 1'b1, 16'h0000, 1'b1}, // ihl zero
    '{8'h46, ipv4cs_pkg::KIND_UDP,  1'b1, 1'b1, 16'h0000, 1'b1}, // last on the first byte
    '{8'hff, ipv4cs_pkg::KIND_ICMP, 1'b0, 1'b0, 16'h0000, 1'b0}, // ihl 15 ...
    '{8'h00, ipv4cs_pkg::KIND_UDP,  1'b1, 1'b1, 16'h0000, 1'b1}, // ... cut after two bytes
    '{8'h45, ipv4cs_pkg::KIND_IP,   1'b0, 1'b0, 16'h0000, 1'b0},
    '{8'h00, ipv4cs_pkg::KIND_TCP,  1'b0, 1'b0, 16'h0000, 1'b0},
    '{8'h00, ipv4cs_pkg::KIND_UDP,  1'b0, 1'b0, 16'h0000, 1'b0},
    '{8'h73, ipv4cs_pkg::KIND_ICMP, 1'b0, 1'b0, 16'h0000, 1'b0},
    '{8'h00, ipv4cs_pkg::KIND_TCP,  1'b0, 1'b0, 16'h0000, 1'b0},
    '{8'h00, ipv4cs_pkg::KIND_IP,   1'b0, 1'b0, 16'h0000, 1'b0},
    '{8'h40, ipv4cs_pkg::KIND_UDP,  1'b0, 1'b0, 16'h0000, 1'b0},
    '{8'h00, ipv4cs_pkg::KIND_ICMP, 1'b0, 1'b0, 16'h0000, 1'b0},
    '{8'h40, ipv4cs_pkg::KIND_TCP,  1'b0, 1'b0, 16'h0000, 1'b0},
    '{8'h11, ipv4cs_pkg::KIND_IP,   1'b0, 1'b0, 16'h0000, 1'b0},
    '{8'hb8, ipv4cs_pkg::KIND_UDP,  1'b0, 1'b0, 16'h0000, 1'b0}, // stored header checksum
    '{8'h61, ipv4cs_pkg::KIND_ICMP, 1'b0, 1'b0, 16'h0000, 1'b0},
    '{8'hc0, ipv4cs_pkg::KIND_TCP,  1'b0, 1'b0, 16'h0000, 1'b0},
    '{8'ha8, ipv4cs_pkg::KIND_IP,   1'b0, 1'b0, 16'h0000, 1'b0},
    '{8'h00, ipv4cs_pkg::KIND_UDP,  1'b0, 1'b0, 16'h0000, 1'b0},
    '{8'h01, ipv4cs_pkg::KIND_ICMP, 1'b0, 1'b0, 16'h0000, 1'b0},
    '{8'hc0, ipv4cs_pkg::KIND_TCP,  1'b0, 1'b0, 16'h0000, 1'b0},
    '{8'ha8, ipv4cs_pkg::KIND_IP,   1'b0, 1'b0, 16'h0000, 1'b0},
    '{8'h00, ipv4cs_pkg::KIND_UDP,  1'b0, 1'b0, 16'h0000, 1'b0},
    '{8'hc7, ipv4cs_pkg::KIND_ICMP, 1'b1, 1'b1, 16'hb861, 1'b0}
  };

  row_t                stim_feed [$];
  ipv4cs_pkg::result_t cksum_expect_q [$];
  int                  fail_count = 0;

  // predictor state, mirrors one packet in flight
  logic [15:0]       pos_q = '0;
  logic [3:0]        ihl_q = '0;
  logic [15:0]       sum_q = '0;
  logic [7:0]        hi_q = '0;
  ipv4cs_pkg::kind_t kind_q = ipv4cs_pkg::KIND_IP;
  bit                in_seg_q = 1'b0;

  // ones-complement add, end-around carry
  function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] t;
    t = {1'b0, a} + {1'b0, b};
    return t[15:0] + {15'd0, t[16]};
  endfunction

  // fold one accepted byte into the running checksum; on the last byte
  // hand back the packet's result and clear state
  task automatic fold_byte(input logic [7:0] b, input logic [1:0] op, input logic lst,
                           output bit done, output ipv4cs_pkg::result_t res);
    logic [15:0] at;
    logic [15:0] hlen;
    logic [15:0] seg_ofs;
    bit          was_seg;
    bit          counts;
    at = pos_q;
    was_seg = in_seg_q;
    // mode and header length are latched from the first byte only
    if (at == 16'd0 && !in_seg_q) begin
      ihl_q = b[3:0];
      kind_q = ipv4cs_pkg::kind_t'(op);
    end
    hlen = {10'd0, ihl_q, 2'b00};
    seg_ofs = at - hlen;
    counts = 1'b0;
    if (!was_seg) begin
      // header bytes: ip sums all but its own checksum, tcp/udp take the
      // pseudo-header fields, icmp skips the header entirely
      case (kind_q)
        ipv4cs_pkg::KIND_IP:
          counts = at != ipv4cs_pkg::IP_CKSUM_HI_OFS && at != ipv4cs_pkg::IP_CKSUM_LO_OFS;
        ipv4cs_pkg::KIND_TCP, ipv4cs_pkg::KIND_UDP:
          counts = at == ipv4cs_pkg::IP_PROTO_OFS ||
                   (at >= ipv4cs_pkg::IP_SRC_FIRST && at <= ipv4cs_pkg::IP_DST_LAST);
        default:
          counts = 1'b0;
      endcase
    end else begin
      // segment bytes: the protocol's own checksum field reads as zero,
      // matched on the wrapped offset
      case (kind_q)
        ipv4cs_pkg::KIND_IP:
          counts = 1'b0;
        ipv4cs_pkg::KIND_TCP:
          counts = seg_ofs != ipv4cs_pkg::TCP_CKSUM_OFS &&
                   seg_ofs != ipv4cs_pkg::TCP_CKSUM_OFS + 1;
        ipv4cs_pkg::KIND_UDP:
          counts = seg_ofs != ipv4cs_pkg::UDP_CKSUM_OFS &&
                   seg_ofs != ipv4cs_pkg::UDP_CKSUM_OFS + 1;
        default:
          counts = seg_ofs != ipv4cs_pkg::ICMP_CKSUM_OFS &&
                   seg_ofs != ipv4cs_pkg::ICMP_CKSUM_OFS + 1;
      endcase
    end
    if (!at[0]) begin
      hi_q = counts ? b : 8'h00;
    end else begin
      sum_q = ones_add(sum_q, {hi_q, counts ? b : 8'h00});
    end
    if (!in_seg_q && ({1'b0, at} + 17'd1 >= {1'b0, hlen})) begin
      in_seg_q = 1'b1;
    end
    pos_q = at + 16'd1;
    done = lst;
    res = '0;
    if (lst) begin
      // odd tail byte padded with a zero low byte
      if (!at[0]) begin
        sum_q = ones_add(sum_q, {hi_q, 8'h00});
      end
      // pseudo-header segment length, wraps with the position counter
      if (kind_q == ipv4cs_pkg::KIND_TCP || kind_q == ipv4cs_pkg::KIND_UDP) begin
        sum_q = ones_add(sum_q, pos_q - hlen);
      end
      if (ihl_q < ipv4cs_pkg::MIN_IHL || !in_seg_q) begin
        res.checksum = 16'h0000;
        res.short_packet = 1'b1;
      end else begin
        res.checksum = ~sum_q;
        res.short_packet = 1'b0;
      end
      pos_q = '0;
      ihl_q = '0;
      sum_q = '0;
      hi_q = '0;
      kind_q = ipv4cs_pkg::KIND_IP;
      in_seg_q = 1'b0;
    end
  endtask

  // queue one packet: given first byte and mode, random content after it,
  // random opcodes on the later bytes
  task automatic push_packet(input int unsigned len, input logic [7:0] first,
                             input ipv4cs_pkg::kind_t kind);
    row_t r;
    for (int unsigned i = 0; i < len; i++) begin
      r = '0;
      r.data = (i == 0) ? first : 8'($urandom);
      r.op = (i == 0) ? kind : ipv4cs_pkg::kind_t'($urandom_range(0, 3));
      r.lst = (i == len - 1);
      stim_feed.push_back(r);
    end
  endtask

  // sender, predictor and result check share one edge-driven process so the
  // push of an expectation and the pop against a result never race
  always @(posedge clk) begin : xfer
    row_t                cur;
    int                  burst_left;
    int                  gap_left;
    bit                  got;
    ipv4cs_pkg::result_t predicted;
    ipv4cs_pkg::result_t want;
    if (rst_n) begin
      // input transaction accepted at this edge
      if (in_valid && !in_stall) begin
        fold_byte(cur.data, cur.op, cur.lst, got, predicted);
        if (got) begin
          if (cur.typed) begin
            want.checksum = cur.ck;
            want.short_packet = cur.sp;
            cksum_expect_q.push_back(want);
          end else begin
            cksum_expect_q.push_back(predicted);
          end
        end
      end
      // result transaction accepted at this edge
      if (out_valid && !out_stall) begin
        if (cksum_expect_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) begin
            $display("unexpected result: checksum %h short %b", out_checksum, out_short_packet);
          end
        end else begin
          want = cksum_expect_q.pop_front();
          if (out_checksum !== want.checksum || out_short_packet !== want.short_packet) begin
            fail_count++;
            if (fail_count <= 10) begin
              $display("mismatch: checksum exp %h got %h, short exp %b got %b",
                       want.checksum, out_checksum, want.short_packet, out_short_packet);
            end
          end
        end
      end
      // a held transaction stays put until taken; otherwise pick the next
      // byte or idle, in bursts with random gaps between them
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (stim_feed.size() != 0) begin
          cur = stim_feed.pop_front();
          in_valid <= 1'b1;
          in_data_byte <= cur.data;
          in_opcode <= cur.op;
          in_last <= cur.lst;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 60);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left--;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver stall pattern: phases of no stall, coin-flip, mostly stalled
  // and periodic; twice a long hold-off while the sender keeps going, so
  // a result backs up and the next final byte has to wait at the input
  always @(posedge clk) begin : recv_pattern
    int unsigned cyc;
    int unsigned results_taken;
    int unsigned hold_left;
    cyc++;
    if (rst_n && out_valid && !out_stall) begin
      results_taken++;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (rst_n && out_valid && !out_stall &&
                 (results_taken == 15 || results_taken == 35)) begin
      hold_left = 400;
      out_stall <= 1'b1;
    end else begin
      case ((cyc >> 7) % 4)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 1) == 0);
        2: out_stall <= ($urandom_range(0, 3) != 0);
        default: out_stall <= (cyc % 3 == 0);
      endcase
    end
  end

  initial begin : main
    int unsigned rand_bytes;
    int unsigned rand_pkts;
    int unsigned ihl;
    int unsigned len;
    for (int i = 0; i < 25; i++) begin
      stim_feed.push_back(directed_tab[i]);
    end
    // mostly well-formed packets with random content, the rest malformed
    // or truncated headers
    rand_bytes = 0;
    rand_pkts = 0;
    while (rand_bytes < 1525 || rand_pkts < 30) begin
      if ($urandom_range(0, 4) != 0) begin
        ihl = $urandom_range(0, 1) ? 5 : $urandom_range(5, 15);
        len = ihl * 4 + $urandom_range(0, 41);
      end else begin
        ihl = $urandom_range(0, 15);
        len = $urandom_range(1, ihl * 4 + 2);
      end
      push_packet(len, {4'($urandom), 4'(ihl)},
                  ipv4cs_pkg::kind_t'($urandom_range(0, 3)));
      rand_bytes += len;
      rand_pkts++;
    end
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    // checked on the falling edge, away from the driver's updates
    @(negedge clk);
    while (stim_feed.size() != 0 || in_valid) @(negedge clk);
    while (cksum_expect_q.size() != 0) @(negedge clk);
    // catch any stray result
    repeat (20) @(negedge clk);
    if (fail_count == 0 && cksum_expect_q.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin : watchdog
    #25_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
